// ----- hw/rtl/rgb_to_hsv_pixel_top_defines.svh -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_top_defines.svh
// Assertion macros used by the port-level checker of the color conversion block.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_TOP_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define RTH_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define RTH_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rth_pkg.sv -----
// ----------------------------------------------------------------------------
// rth_pkg
// Widths, types and the divider step of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rth_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int FRACTION_BITS = 16;
    // divisor is at most 6 * chroma, so three bits above a channel
    localparam int DIV_BITS      = CHANNEL_BITS + 3;
    // signed sector term, down to -chroma and up to 5 * chroma
    localparam int NUM_BITS      = CHANNEL_BITS + 4;
    localparam int FRONT_STAGES  = 2;
    localparam int LATENCY       = FRONT_STAGES + FRACTION_BITS;

    typedef logic [CHANNEL_BITS-1:0]  chan_t;
    typedef logic [FRACTION_BITS-1:0] frac_t;
    typedef logic [DIV_BITS-1:0]      dword_t;
    typedef logic signed [NUM_BITS-1:0] num_t;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    typedef struct packed {
        chan_t brightness;
        logic  sat_full;
    } side_t;

    typedef struct packed {
        dword_t rem;
        logic   qbit;
    } step_t;

    // One restoring division step; requires rem < den on entry.
    function automatic step_t div_step(input dword_t rem, input dword_t den);
        logic [DIV_BITS:0] rem2;
        logic [DIV_BITS:0] den2;
        step_t             res;
        rem2 = {rem, 1'b0};
        den2 = {1'b0, den};
        if (rem2 >= den2)
        begin
            res.qbit = 1'b1;
            res.rem  = DIV_BITS'(rem2 - den2);
        end
        else
        begin
            res.qbit = 1'b0;
            res.rem  = rem2[DIV_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/rth_div_pipe.sv -----
// ----------------------------------------------------------------------------
// rth_div_pipe
// Two-lane pipelined fraction divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rth_div_pipe
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  rth_pkg::dword_t hue_num,
    input  rth_pkg::dword_t hue_den,
    input  rth_pkg::dword_t sat_num,
    input  rth_pkg::dword_t sat_den,
    input  rth_pkg::side_t in_side,
    output logic           out_valid,
    output rth_pkg::frac_t hue_q,
    output rth_pkg::frac_t sat_q,
    output rth_pkg::side_t out_side
);
    import rth_pkg::*;

    localparam int STAGES = FRACTION_BITS;

    logic   valid_reg    [STAGES];
    dword_t hue_rem_reg  [STAGES];
    dword_t hue_den_reg  [STAGES];
    frac_t  hue_quo_reg  [STAGES];
    dword_t sat_rem_reg  [STAGES];
    dword_t sat_den_reg  [STAGES];
    frac_t  sat_quo_reg  [STAGES];
    side_t  side_reg     [STAGES];

    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_stage
            logic   valid_prev;
            dword_t hue_rem_prev;
            dword_t hue_den_prev;
            frac_t  hue_quo_prev;
            dword_t sat_rem_prev;
            dword_t sat_den_prev;
            frac_t  sat_quo_prev;
            side_t  side_prev;
            step_t  hue_step;
            step_t  sat_step;

            if (k == 0)
            begin : g_first
                assign valid_prev   = in_valid;
                assign hue_rem_prev = hue_num;
                assign hue_den_prev = hue_den;
                assign hue_quo_prev = '0;
                assign sat_rem_prev = sat_num;
                assign sat_den_prev = sat_den;
                assign sat_quo_prev = '0;
                assign side_prev    = in_side;
            end
            else
            begin : g_next
                assign valid_prev   = valid_reg[k-1];
                assign hue_rem_prev = hue_rem_reg[k-1];
                assign hue_den_prev = hue_den_reg[k-1];
                assign hue_quo_prev = hue_quo_reg[k-1];
                assign sat_rem_prev = sat_rem_reg[k-1];
                assign sat_den_prev = sat_den_reg[k-1];
                assign sat_quo_prev = sat_quo_reg[k-1];
                assign side_prev    = side_reg[k-1];
            end

            assign hue_step = div_step(hue_rem_prev, hue_den_prev);
            assign sat_step = div_step(sat_rem_prev, sat_den_prev);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else
                begin
                    valid_reg[k] <= valid_prev;
                end
            end

            // shift the new quotient bit in at the bottom
            always_ff @(posedge clk)
            begin
                hue_rem_reg[k] <= hue_step.rem;
                hue_den_reg[k] <= hue_den_prev;
                hue_quo_reg[k] <= {hue_quo_prev[FRACTION_BITS-2:0], hue_step.qbit};
                sat_rem_reg[k] <= sat_step.rem;
                sat_den_reg[k] <= sat_den_prev;
                sat_quo_reg[k] <= {sat_quo_prev[FRACTION_BITS-2:0], sat_step.qbit};
                side_reg[k]    <= side_prev;
            end
        end
    endgenerate

    assign out_valid = valid_reg[STAGES-1];
    assign hue_q     = hue_quo_reg[STAGES-1];
    assign sat_q     = sat_quo_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ----- hw/rtl/rgb_to_hsv_pixel_top.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_top: RGB to HSV pixel converter, fully pipelined.
// From start to done a pixel passes two front stages, then one
// divider stage per fraction bit. Throughput is one pixel per cycle; busy
// stays low. Reset clears all valid bits, so no done follows reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_top
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  rth_pkg::chan_t red,
    input  rth_pkg::chan_t green,
    input  rth_pkg::chan_t blue,
    output logic           busy,
    output logic           done,
    output rth_pkg::frac_t hue,
    output rth_pkg::frac_t saturation,
    output rth_pkg::chan_t brightness
);
    import rth_pkg::*;

    // stage 1: max, min and sector
    logic    s1_valid_reg;
    chan_t   s1_red_reg;
    chan_t   s1_green_reg;
    chan_t   s1_blue_reg;
    chan_t   s1_max_reg;
    chan_t   s1_min_reg;
    sector_t s1_sect_reg;
    chan_t   s1_max_next;
    chan_t   s1_min_next;
    sector_t s1_sect_next;

    // stage 2: divider operands
    logic    s2_valid_reg;
    dword_t  s2_hue_num_reg;
    dword_t  s2_hue_den_reg;
    dword_t  s2_sat_num_reg;
    dword_t  s2_sat_den_reg;
    side_t   s2_side_reg;
    dword_t  s2_hue_num_next;
    dword_t  s2_hue_den_next;
    dword_t  s2_sat_num_next;
    dword_t  s2_sat_den_next;
    side_t   s2_side_next;

    chan_t   chroma;
    num_t    chroma_s;
    num_t    sector_num;
    num_t    wrapped_num;
    dword_t  six_chroma;

    logic    div_valid;
    frac_t   div_hue_q;
    frac_t   div_sat_q;
    side_t   div_side;

    assign busy = 1'b0;

    // ties prefer red, then green
    always_comb
    begin
        if (red >= green && red >= blue)
        begin
            s1_sect_next = SECT_RED;
            s1_max_next  = red;
        end
        else if (green >= blue)
        begin
            s1_sect_next = SECT_GREEN;
            s1_max_next  = green;
        end
        else
        begin
            s1_sect_next = SECT_BLUE;
            s1_max_next  = blue;
        end
        s1_min_next = red;
        if (green < s1_min_next)
        begin
            s1_min_next = green;
        end
        if (blue < s1_min_next)
        begin
            s1_min_next = blue;
        end
    end

    always_comb
    begin
        chroma     = s1_max_reg - s1_min_reg;
        chroma_s   = num_t'({4'b0000, chroma});
        six_chroma = DIV_BITS'({chroma, 2'b00}) + DIV_BITS'({chroma, 1'b0});
        case (s1_sect_reg)
            SECT_RED:
                sector_num = num_t'({4'b0000, s1_green_reg})
                           - num_t'({4'b0000, s1_blue_reg});
            SECT_GREEN:
                sector_num = (chroma_s <<< 1) + num_t'({4'b0000, s1_blue_reg})
                           - num_t'({4'b0000, s1_red_reg});
            default:
                sector_num = (chroma_s <<< 2) + num_t'({4'b0000, s1_red_reg})
                           - num_t'({4'b0000, s1_green_reg});
        endcase
        wrapped_num = sector_num;
        if (sector_num < 0)
        begin
            wrapped_num = sector_num + num_t'({1'b0, six_chroma});
        end

        // gray pixel: feed 0 / 1 so the quotient comes out zero
        if (chroma == '0)
        begin
            s2_hue_num_next = '0;
            s2_hue_den_next = DIV_BITS'(1);
        end
        else
        begin
            s2_hue_num_next = wrapped_num[DIV_BITS-1:0];
            s2_hue_den_next = six_chroma;
        end

        // black pixel or ratio of one: bypass the divider
        s2_side_next.brightness = s1_max_reg;
        s2_side_next.sat_full   = (s1_max_reg != '0) && (s1_min_reg == '0);
        if (s1_max_reg == '0 || s1_min_reg == '0)
        begin
            s2_sat_num_next = '0;
            s2_sat_den_next = DIV_BITS'(1);
        end
        else
        begin
            s2_sat_num_next = DIV_BITS'(chroma);
            s2_sat_den_next = DIV_BITS'(s1_max_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_red_reg     <= red;
        s1_green_reg   <= green;
        s1_blue_reg    <= blue;
        s1_max_reg     <= s1_max_next;
        s1_min_reg     <= s1_min_next;
        s1_sect_reg    <= s1_sect_next;
        s2_hue_num_reg <= s2_hue_num_next;
        s2_hue_den_reg <= s2_hue_den_next;
        s2_sat_num_reg <= s2_sat_num_next;
        s2_sat_den_reg <= s2_sat_den_next;
        s2_side_reg    <= s2_side_next;
    end

    rth_div_pipe u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .hue_num   (s2_hue_num_reg),
        .hue_den   (s2_hue_den_reg),
        .sat_num   (s2_sat_num_reg),
        .sat_den   (s2_sat_den_reg),
        .in_side   (s2_side_reg),
        .out_valid (div_valid),
        .hue_q     (div_hue_q),
        .sat_q     (div_sat_q),
        .out_side  (div_side)
    );

    assign done       = div_valid;
    assign hue        = div_hue_q;
    assign saturation = div_side.sat_full ? '1 : div_sat_q;
    assign brightness = div_side.brightness;

endmodule

// ----- hw/rtl/rth_checker.sv -----
// ----------------------------------------------------------------------------
// rth_checker
// Port-level checks of the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_pixel_top_defines.svh"

module rth_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input rth_pkg::chan_t red,
    input rth_pkg::chan_t green,
    input rth_pkg::chan_t blue,
    input logic           busy,
    input logic           done,
    input rth_pkg::frac_t hue,
    input rth_pkg::frac_t saturation,
    input rth_pkg::chan_t brightness
);
    import rth_pkg::*;

    `RTH_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
    `RTH_ASSERT_IMPLY(a_done_has_start, done, $past(start, LATENCY),
        "done without a start one latency earlier")
    `RTH_ASSERT_IMPLY(a_value_is_max, done,
        brightness >= $past(red, LATENCY) && brightness >= $past(green, LATENCY)
        && brightness >= $past(blue, LATENCY), "brightness below a channel")
    `RTH_ASSERT_IMPLY(a_black_pixel, done && brightness == '0,
        hue == '0 && saturation == '0, "black pixel with nonzero hue or saturation")

endmodule

bind rgb_to_hsv_pixel_top rth_checker u_rth_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .busy       (busy),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
);

// ----- dv/rgb_to_hsv_pixel_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_checker
// Watches the pixel and result channels of the RGB to HSV converter. It
// predicts hue, saturation and brightness for every accepted pixel and
// compares each done word, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  rth_pkg::chan_t red,
    input  rth_pkg::chan_t green,
    input  rth_pkg::chan_t blue,
    input  logic           done,
    input  rth_pkg::frac_t hue,
    input  rth_pkg::frac_t saturation,
    input  rth_pkg::chan_t brightness,
    output int             fail_count,
    output int             pending
);
    import rth_pkg::*;

    localparam longint unsigned FRAC_MAX = (64'd1 << FRACTION_BITS) - 1;
    localparam int              REPORT_MAX = 10;

    typedef struct packed {
        frac_t hue;
        frac_t sat;
        chan_t val;
    } hsv_t;

    hsv_t hsv_expected[$];

    function automatic hsv_t predict_hsv(input chan_t r, input chan_t g, input chan_t b);
        chan_t             hi;
        chan_t             lo;
        int                rv;
        int                gv;
        int                bv;
        int                chroma;
        int                sector_num;
        longint unsigned   ratio;
        longint unsigned   divisor;
        hsv_t              res;
        rv = r;
        gv = g;
        bv = b;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        chroma  = int'(hi) - int'(lo);
        res.val = hi;
        res.sat = '0;
        res.hue = '0;
        if (hi != 0)
        begin
            ratio   = longint'(chroma);
            divisor = longint'(hi);
            ratio   = (ratio << FRACTION_BITS) / divisor;
            if (ratio > FRAC_MAX) ratio = FRAC_MAX;
            res.sat = frac_t'(ratio);
        end
        if (chroma != 0)
        begin
            // ties go to red first, then green
            if (hi == r)
                sector_num = gv - bv;
            else if (hi == g)
                sector_num = 2 * chroma + (bv - rv);
            else
                sector_num = 4 * chroma + (rv - gv);
            if (sector_num < 0) sector_num += 6 * chroma;
            ratio   = longint'(sector_num);
            divisor = longint'(6 * chroma);
            ratio   = (ratio << FRACTION_BITS) / divisor;
            if (ratio > FRAC_MAX) ratio = FRAC_MAX;
            res.hue = frac_t'(ratio);
        end
        return res;
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        hsv_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (hsv_expected.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: unexpected word hue=%h sat=%h val=%h",
                                 $realtime, hue, saturation, brightness);
                end
                else
                begin
                    want = hsv_expected.pop_front();
                    if (hue !== want.hue || saturation !== want.sat ||
                        brightness !== want.val)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display({"%0t: wrong word exp hue=%h sat=%h val=%h, ",
                                      "got hue=%h sat=%h val=%h"},
                                     $realtime, want.hue, want.sat, want.val,
                                     hue, saturation, brightness);
                    end
                end
            end
            if (start && !busy)
                hsv_expected.push_back(predict_hsv(red, green, blue));
            pending = hsv_expected.size();
        end
    end

endmodule

// ----- dv/tb_rgb_to_hsv_pixel_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_pixel_top
// Drives the RGB to HSV converter with directed corner pixels and then
// random pixels biased toward ties, grays and extreme channels, in gapped
// and back-to-back runs. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_pixel_top;
    import rth_pkg::*;

    localparam int RANDOM_PIXELS = 1750;
    localparam int IDLE_LIMIT    = 1000;
    localparam int DIRECTED_NUM  = 22;

    // {red, green, blue}
    localparam logic [23:0] DIRECTED [DIRECTED_NUM] = '{
        24'h000000, 24'hffffff, 24'h808080, 24'h010101,
        24'hff0000, 24'h00ff00, 24'h0000ff,
        24'hff00ff, 24'hffff00, 24'h00ffff,
        24'hff0001, 24'h010000, 24'h000100, 24'h000001,
        24'hfffe00, 24'h00fffe, 24'hfe00ff,
        24'hff0080, 24'hc86432, 24'h0a0b0c,
        24'hfefeff, 24'h7f80ff
    };

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    chan_t red = '0;
    chan_t green = '0;
    chan_t blue = '0;
    logic  busy;
    logic  done;
    frac_t hue;
    frac_t saturation;
    chan_t brightness;
    int    fail_count;
    int    pending;
    int    idle_cycles = 0;
    logic  burst_mode = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    rgb_to_hsv_pixel_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .busy       (busy),
        .done       (done),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    rgb_to_hsv_pixel_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .done       (done),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Hold start across back-to-back words; drop it only for a gap.
    task automatic send_pixel(input logic [23:0] rgb);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        red   <= rgb[23:16];
        green <= rgb[15:8];
        blue  <= rgb[7:0];
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    function automatic chan_t extreme_chan();
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h01;
            3:       return 8'hfe;
            default: return chan_t'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] random_pixel();
        chan_t a;
        chan_t c;
        int    kind;
        int    pick;
        a    = chan_t'($urandom);
        c    = chan_t'($urandom);
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 2);
        if (kind < 55)
            return 24'($urandom);
        else if (kind < 70)
        begin
            // two channels equal
            if (pick == 0) return {a, a, c};
            if (pick == 1) return {a, c, a};
            return {c, a, a};
        end
        else if (kind < 78)
            return {a, a, a};
        else if (kind < 90)
            return {extreme_chan(), extreme_chan(), extreme_chan()};
        else
        begin
            // near gray, small chroma
            c = a ^ chan_t'($urandom_range(0, 3));
            if (pick == 0) return {c, a, a ^ chan_t'($urandom_range(0, 3))};
            if (pick == 1) return {a, c, a ^ chan_t'($urandom_range(0, 3))};
            return {a ^ chan_t'($urandom_range(0, 3)), a, c};
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("rgb_to_hsv_pixel_top: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            burst_mode = (i >= 10);
            send_pixel(DIRECTED[i]);
        end

        for (int n = 0; n < RANDOM_PIXELS; n++)
        begin
            // switch between gapped and back-to-back stretches
            if (n % 50 == 0)
                burst_mode = ($urandom_range(0, 2) == 0);
            send_pixel(random_pixel());
        end
        start <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("rgb_to_hsv_pixel_top: match");
        else
            $display("rgb_to_hsv_pixel_top: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/rth_pkg.sv
hw/rtl/rth_div_pipe.sv
hw/rtl/rgb_to_hsv_pixel_top.sv
hw/rtl/rth_checker.sv
dv/rgb_to_hsv_pixel_checker.sv
dv/tb_rgb_to_hsv_pixel_top.sv
